@@ hdl/hsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hsd_pkg;

  localparam int EDGE_COUNT_BITS_DEF = 32;
  localparam int CODE_W              = 3;
  localparam int ANGLE_UNIT_W        = 13;
  localparam int ANGLE_W             = 16;
  localparam int MULT_W              = 4;
  localparam int ERROR_COUNT_W       = 16;
  localparam int EDGE_OUT_W          = 32;
  localparam int CFG_INDEX_W         = 1;
  localparam int CFG_DATA_W          = ANGLE_UNIT_W;

  localparam logic [ANGLE_UNIT_W-1:0] ANGLE_UNIT_RESET = 13'd5461;
  localparam logic                    PLACEMENT_RESET  = 1'b0;

  localparam logic [CFG_INDEX_W-1:0] CFG_PLACEMENT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_UNIT = 1'd1;

  localparam logic PLACE_120 = 1'b0;
  localparam logic PLACE_60  = 1'b1;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } stage_t;

  localparam int NUM_PAIRS = 12;

  localparam logic [7:0] FWD_PAIRS [NUM_PAIRS] = '{
    8'h45, 8'h51, 8'h13, 8'h32, 8'h26, 8'h64,
    8'h41, 8'h53, 8'h12, 8'h36, 8'h24, 8'h65
  };
  localparam logic [7:0] BWD_PAIRS [NUM_PAIRS] = '{
    8'h62, 8'h23, 8'h31, 8'h15, 8'h54, 8'h46,
    8'h63, 8'h21, 8'h35, 8'h14, 8'h56, 8'h42
  };

  // multiple of the 30 degree unit per code, zero for an invalid code
  function automatic logic [MULT_W-1:0] code_multiple(input logic [CODE_W-1:0] code);
    logic [MULT_W-1:0] m;
    unique case (code)
      3'd1:    m = 4'd3;
      3'd2:    m = 4'd7;
      3'd3:    m = 4'd5;
      3'd4:    m = 4'd11;
      3'd5:    m = 4'd1;
      3'd6:    m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic dir_t dir_lookup(input logic [CODE_W-1:0] prev,
                                      input logic [CODE_W-1:0] cur);
    logic [7:0] pair;
    logic       fwd;
    logic       bwd;
    dir_t       d;
    pair = {1'b0, prev, 1'b0, cur};
    fwd  = 1'b0;
    bwd  = 1'b0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      if (pair == FWD_PAIRS[i]) fwd = 1'b1;
      if (pair == BWD_PAIRS[i]) bwd = 1'b1;
    end
    if (fwd)      d = DIR_FWD;
    else if (bwd) d = DIR_BWD;
    else          d = DIR_IDLE;
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hdl/hsd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface hsd_in_if;
  logic valid;
  logic ready;
  logic hall_a;
  logic hall_b;
  logic hall_c;

  modport source (output valid, output hall_a, output hall_b, output hall_c, input ready);
  modport sink   (input valid, input hall_a, input hall_b, input hall_c, output ready);
endinterface

interface hsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  hall_code;
  logic [15:0] sector_angle;
  logic [1:0]  direction;
  logic [31:0] edge_count;
  logic [15:0] error_count;
  logic        code_invalid;

  modport source (output valid, output hall_code, output sector_angle, output direction,
                  output edge_count, output error_count, output code_invalid,
                  input ready);
  modport sink   (input valid, input hall_code, input sector_angle, input direction,
                  input edge_count, input error_count, input code_invalid,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/hall_sensor_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Hall sensor decoder core.
// in_ch carries one settled sample of the three hall levels per transfer
// (valid/ready). out_ch returns one result per input transfer: packed hall
// code, sector angle, direction, edge and error counts, and an invalid flag.
// The cfg port writes placement (index 0) and the 30 degree angle unit
// (index 1) on any edge with cfg_we high; write only while no sample is
// in flight.
// A sample taken from in_ch passes an input register and then a result register
// before it shows on out_ch. Throughput: one sample per cycle while out_ch.ready
// is high, set by the result stage updating its state on every transfer.
// Reset (synchronous, rst_n low): both stages empty, angle, direction,
// last code and counters cleared, placement = 120 degree, angle unit 5461.
// When out_ch.ready is low the result holds; one more sample is parked in
// the input register, after which in_ch.ready drops until the result
// transfer completes.
module hall_sensor_decoder_core
  import hsd_pkg::*;
#(
  parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  hsd_in_if.sink                      in_ch,
  hsd_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic                    placement_r;
  logic [ANGLE_UNIT_W-1:0] angle_unit_r;
  stage_t                  s1;
  logic                    s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placement_r  <= PLACEMENT_RESET;
      angle_unit_r <= ANGLE_UNIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLACEMENT:  placement_r  <= cfg_wdata[0];
        CFG_ANGLE_UNIT: angle_unit_r <= cfg_wdata[ANGLE_UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  hsd_sample u_sample (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .placement (placement_r),
    .s2_ready  (s2_ready),
    .s1        (s1)
  );

  hsd_track #(
    .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .angle_unit (angle_unit_r),
    .s2_ready   (s2_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

@@ hdl/hsd_sample.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hsd_sample
  import hsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  hsd_in_if.sink      in_ch,
  input  wire logic   placement,
  input  wire logic   s2_ready,
  output stage_t      s1
);

  logic              valid_r;
  logic              valid_nxt;
  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] code_nxt;
  logic              take;

  assign in_ch.ready = !valid_r || s2_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (placement == PLACE_60) begin
      code_nxt = {~in_ch.hall_b, in_ch.hall_c, in_ch.hall_a};
    end else begin
      code_nxt = {in_ch.hall_c, in_ch.hall_b, in_ch.hall_a};
    end
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= code_nxt;
    end
  end

  assign s1 = '{valid: valid_r, code: code_r};

endmodule
`default_nettype wire

@@ hdl/hsd_track.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hsd_track
  import hsd_pkg::*;
#(
  parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire stage_t                  s1,
  input  wire logic [ANGLE_UNIT_W-1:0] angle_unit,
  output logic                         s2_ready,
  hsd_out_if.source                    out_ch
);

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [CODE_W-1:0]          last_code_r;
  logic [CODE_W-1:0]          last_code_nxt;
  logic [ANGLE_W-1:0]         angle_r;
  logic [ANGLE_W-1:0]         angle_nxt;
  dir_t                       dir_r;
  dir_t                       dir_nxt;
  logic [EDGE_COUNT_BITS-1:0] edge_cnt_r;
  logic [EDGE_COUNT_BITS-1:0] edge_cnt_nxt;
  logic [ERROR_COUNT_W-1:0]   err_cnt_r;
  logic [ERROR_COUNT_W-1:0]   err_cnt_nxt;
  logic                       invalid_r;
  logic                       invalid_nxt;
  logic [MULT_W-1:0]          mult;
  logic [ANGLE_UNIT_W+MULT_W-1:0] product;
  logic                       take;

  assign s2_ready = !out_valid_r || out_ch.ready;
  assign take     = s1.valid && s2_ready;

  always_comb begin
    mult          = code_multiple(s1.code);
    product       = (ANGLE_UNIT_W+MULT_W)'(angle_unit) * (ANGLE_UNIT_W+MULT_W)'(mult);
    invalid_nxt   = (mult == '0);
    last_code_nxt = s1.code;
    angle_nxt     = angle_r;
    err_cnt_nxt   = err_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    dir_nxt       = dir_r;
    if (invalid_nxt) begin
      err_cnt_nxt = err_cnt_r + ERROR_COUNT_W'(1);
    end else begin
      angle_nxt = product[ANGLE_W-1:0];
    end
    if (s1.code != last_code_r) begin
      edge_cnt_nxt = edge_cnt_r + EDGE_COUNT_BITS'(1);
      dir_nxt      = dir_lookup(last_code_r, s1.code);
    end
    if (s2_ready) begin
      out_valid_nxt = s1.valid;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_code_r <= '0;
      angle_r     <= '0;
      dir_r       <= DIR_IDLE;
      edge_cnt_r  <= '0;
      err_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        last_code_r <= last_code_nxt;
        angle_r     <= angle_nxt;
        dir_r       <= dir_nxt;
        edge_cnt_r  <= edge_cnt_nxt;
        err_cnt_r   <= err_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      invalid_r <= invalid_nxt;
    end
  end

  generate
    if (EDGE_COUNT_BITS >= EDGE_OUT_W) begin : g_edge_wide
      assign out_ch.edge_count = edge_cnt_r[EDGE_OUT_W-1:0];
    end else begin : g_edge_narrow
      assign out_ch.edge_count = EDGE_OUT_W'(edge_cnt_r);
    end
  endgenerate

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hall_code    = last_code_r;
  assign out_ch.sector_angle = angle_r;
  assign out_ch.direction    = dir_r;
  assign out_ch.error_count  = err_cnt_r;
  assign out_ch.code_invalid = invalid_r;

endmodule
`default_nettype wire

@@ hdl/hsd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  hall_code,
  input wire logic [15:0] sector_angle,
  input wire logic [1:0]  direction,
  input wire logic [31:0] edge_count,
  input wire logic [15:0] error_count,
  input wire logic        code_invalid
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hall_code) && $stable(sector_angle)
      && $stable(direction) && $stable(edge_count) && $stable(error_count)
      && $stable(code_invalid))
    else $error("result changed while stalled");

  a_invalid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> code_invalid == (hall_code == 3'd0 || hall_code == 3'd7))
    else $error("invalid flag does not match hall code");

  a_direction_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> direction != 2'd3)
    else $error("undefined direction code");

endmodule

bind hall_sensor_decoder_core hsd_checker u_hsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hall_code    (out_ch.hall_code),
  .sector_angle (out_ch.sector_angle),
  .direction    (out_ch.direction),
  .edge_count   (out_ch.edge_count),
  .error_count  (out_ch.error_count),
  .code_invalid (out_ch.code_invalid)
);
`default_nettype wire

@@ tb/hall_sensor_decoder_core_tb.sv @@
`timescale 1ns / 1ps
module hall_sensor_decoder_core_tb;
  import hsd_pkg::*;

  localparam int LONG_HOLD      = 100;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic c;
    logic b;
    logic a;
  } hall_levels_t;

  typedef struct {
    logic [CODE_W-1:0]        code;
    logic [ANGLE_W-1:0]       angle;
    dir_t                     dir;
    logic [EDGE_OUT_W-1:0]    edges;
    logic [ERROR_COUNT_W-1:0] errors;
    logic                     invalid;
  } hall_result_t;

  // commutation order in the forward direction
  localparam logic [CODE_W-1:0] RING [6] = '{3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  hsd_in_if  in_ch ();
  hsd_out_if out_ch ();

  hall_sensor_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hall_levels_t sample_q [$];
  hall_result_t decoded_q [$];

  logic cur_place;
  bit   in_took;
  bit   out_took;
  int   stall_cycles = 0;
  int   mismatches = 0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   hold_req = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   recv_cyc = 0;

  // decoder state mirror
  logic                     m_place;
  logic [ANGLE_UNIT_W-1:0]  m_unit;
  logic [CODE_W-1:0]        m_last;
  logic [ANGLE_W-1:0]       m_angle;
  dir_t                     m_dir;
  logic [EDGE_OUT_W-1:0]    m_edges;
  logic [ERROR_COUNT_W-1:0] m_errors;

  function automatic int ring_pos(input logic [CODE_W-1:0] code);
    for (int i = 0; i < 6; i++) begin
      if (RING[i] == code) return i;
    end
    return -1;
  endfunction

  function automatic hall_result_t decode_hall(input hall_levels_t lv);
    hall_result_t r;
    int           pc;
    int           pp;
    int           step;
    logic [31:0]  prod;
    r.code = m_place ? {~lv.b, lv.c, lv.a} : {lv.c, lv.b, lv.a};
    pc = ring_pos(r.code);
    r.invalid = (pc < 0);
    if (r.invalid) begin
      m_errors = m_errors + 1'b1;
    end else begin
      // sector centers sit at odd multiples of 30 degrees
      prod = m_unit * ((2 * pc + 11) % 12);
      m_angle = prod[ANGLE_W-1:0];
    end
    if (r.code != m_last) begin
      m_edges = m_edges + 1'b1;
      pp = ring_pos(m_last);
      if (pc < 0 || pp < 0) begin
        m_dir = DIR_IDLE;
      end else begin
        step = (pc - pp + 6) % 6;
        if (step <= 2) m_dir = DIR_FWD;
        else if (step >= 4) m_dir = DIR_BWD;
        else m_dir = DIR_IDLE;
      end
    end
    m_last = r.code;
    r.angle = m_angle;
    r.dir = m_dir;
    r.edges = m_edges;
    r.errors = m_errors;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch_ports
    hall_result_t want;
    hall_levels_t lv;
    if (!rst_n) begin
      m_place = PLACEMENT_RESET;
      m_unit = ANGLE_UNIT_RESET;
      m_last = '0;
      m_angle = '0;
      m_dir = DIR_IDLE;
      m_edges = '0;
      m_errors = '0;
      in_took = 1'b0;
      out_took = 1'b0;
    end else begin
      in_took = in_ch.valid && in_ch.ready;
      out_took = out_ch.valid && out_ch.ready;
      if (cfg_we) begin
        if (cfg_index == CFG_PLACEMENT) m_place = cfg_wdata[0];
        else if (cfg_index == CFG_ANGLE_UNIT) m_unit = cfg_wdata[ANGLE_UNIT_W-1:0];
      end
      if (out_took) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing expected: hall_code %0d", out_ch.hall_code);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("hall_code", want.code, out_ch.hall_code);
          check_field("sector_angle", want.angle, out_ch.sector_angle);
          check_field("direction", want.dir, out_ch.direction);
          check_field("edge_count", want.edges, out_ch.edge_count);
          check_field("error_count", want.errors, out_ch.error_count);
          check_field("code_invalid", want.invalid, out_ch.code_invalid);
        end
      end
      if (in_took) begin
        lv = '{c: in_ch.hall_c, b: in_ch.hall_b, a: in_ch.hall_a};
        decoded_q.push_back(decode_hall(lv));
      end
    end
    if (in_took || out_took) stall_cycles = 0;
    else stall_cycles++;
  end

  always @(negedge clk) begin : feed_samples
    hall_levels_t lv;
    if (!in_ch.valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        lv = sample_q.pop_front();
        in_ch.hall_a <= lv.a;
        in_ch.hall_b <= lv.b;
        in_ch.hall_c <= lv.c;
        in_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_results
    logic rdy;
    recv_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      rdy = 1'b0;
    end else begin
      case ((recv_cyc / 64) % 8)
        3: begin
          rdy = $urandom_range(0, 1);
        end
        4: begin
          rdy = ($urandom_range(0, 9) != 0);
        end
        5: begin
          rdy = (recv_cyc % 3 != 0);
        end
        6: begin
          rdy = ($urandom_range(0, 3) == 0);
        end
        7: begin
          rdy = (recv_cyc % 8 != 5);
        end
        default: begin
          rdy = 1'b1;
        end
      endcase
    end
    out_ch.ready <= rdy;
  end

  function automatic void push_code(input logic [CODE_W-1:0] code);
    if (cur_place == PLACE_60) sample_q.push_back(hall_levels_t'({code[1], ~code[2], code[0]}));
    else sample_q.push_back(hall_levels_t'(code));
  endfunction

  task automatic wait_idle();
    while (sample_q.size() != 0 || decoded_q.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic place, input logic [ANGLE_UNIT_W-1:0] unit);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PLACEMENT;
    cfg_wdata <= CFG_DATA_W'(place);
    @(negedge clk);
    cfg_index <= CFG_ANGLE_UNIT;
    cfg_wdata <= unit;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_place = place;
  endtask

  // rotation with skips, holds, reversals, glitches and noise
  task automatic gen_rotation(input int n);
    int pos;
    int dstep;
    int r;
    pos = $urandom_range(0, 5);
    dstep = $urandom_range(0, 1) ? 1 : 5;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        pos = (pos + dstep) % 6;
      end else if (r < 65) begin
        pos = (pos + 2 * dstep) % 6;
      end else if (r >= 73 && r < 79) begin
        dstep = 6 - dstep;
        pos = (pos + dstep) % 6;
      end else if (r >= 79 && r < 84) begin
        pos = (pos + 3) % 6;
      end
      if (r >= 84 && r < 92) push_code($urandom_range(0, 1) ? 3'd7 : 3'd0);
      else if (r >= 92) sample_q.push_back(hall_levels_t'(3'($urandom_range(0, 7))));
      else push_code(RING[pos]);
    end
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0]       seq_a [14];
    logic [CODE_W-1:0]       seq_b [6];
    logic [CODE_W-1:0]       seq_c [3];
    logic [CODE_W-1:0]       seq_d [3];
    logic [ANGLE_UNIT_W-1:0] unit;
    seq_a = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd4, 3'd2, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3, 3'd4};
    seq_b = '{3'd4, 3'd5, 3'd1, 3'd0, 3'd3, 3'd7};
    seq_c = '{3'd4, 3'd5, 3'd6};
    seq_d = '{3'd4, 3'd6, 3'd2};
    in_ch.valid = 1'b0;
    in_ch.hall_a = 1'b0;
    in_ch.hall_b = 1'b0;
    in_ch.hall_c = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PLACEMENT;
    cfg_wdata = '0;
    rst_n = 1'b0;
    cur_place = PLACEMENT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: first sample, full ring, skips, invalid codes
    foreach (seq_a[i]) push_code(seq_a[i]);
    set_config(PLACE_60, '0);
    foreach (seq_b[i]) push_code(seq_b[i]);
    // angle product wraps at 16 bits
    set_config(PLACE_60, '1);
    foreach (seq_c[i]) push_code(seq_c[i]);
    set_config(PLACE_120, 13'd5957);
    foreach (seq_d[i]) push_code(seq_d[i]);

    for (int ph = 0; ph < 8; ph++) begin
      unit = ($urandom_range(0, 6) == 0) ? $urandom_range(5958, 8191) : $urandom_range(0, 5957);
      set_config($urandom_range(0, 1), unit);
      if (ph == 2 || ph == 5) hold_req++;
      gen_rotation($urandom_range(110, 160));
    end

    set_config($urandom_range(0, 1), $urandom_range(0, 5957));
    gen_rotation(40);

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("hall_sensor_decoder_core_tb OK");
    end else begin
      $display("hall_sensor_decoder_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("hall_sensor_decoder_core_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hdl/hsd_pkg.sv
hdl/hsd_if.sv
hdl/hsd_sample.sv
hdl/hsd_track.sv
hdl/hall_sensor_decoder_core.sv
hdl/hsd_checker.sv
tb/hall_sensor_decoder_core_tb.sv
